@@ rtl/srp_pkg.sv @@
// Shared types and codes for the supervisor restart policy block.
// Used by srp_cfg, srp_win and supervisor_restart_policy; depends on nothing.
`default_nettype none

package srp_pkg;

    // Result action codes
    localparam logic [2:0] ACT_IGNORED      = 3'd0;
    localparam logic [2:0] ACT_NO_RESTART   = 3'd1;
    localparam logic [2:0] ACT_RESTART      = 3'd2;
    localparam logic [2:0] ACT_INTENSITY    = 3'd3;
    localparam logic [2:0] ACT_BAD_STRATEGY = 3'd4;
    localparam logic [2:0] ACT_HALTED       = 3'd5;

    // Restart strategies
    localparam logic [1:0] STRAT_ONE_FOR_ONE  = 2'd0;
    localparam logic [1:0] STRAT_ONE_FOR_ALL  = 2'd1;
    localparam logic [1:0] STRAT_REST_FOR_ONE = 2'd2;
    localparam logic [1:0] STRAT_UNKNOWN      = 2'd3;

    // Per-child restart kinds
    localparam logic [1:0] KIND_PERMANENT = 2'd0;
    localparam logic [1:0] KIND_TRANSIENT = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] REG_STRATEGY      = 3'd0;
    localparam logic [2:0] REG_RESTART_LIMIT = 3'd1;
    localparam logic [2:0] REG_PERIOD_MS     = 3'd2;
    localparam logic [2:0] REG_CHILD_COUNT   = 3'd3;
    localparam logic [2:0] REG_RESTART_TYPES = 3'd4;

    // Children supervised; ties to the 4-bit index, 5-bit count and 2-bit kinds
    localparam int MAX_CHILDREN = 16;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int TIME_W    = 64;
    // period_ms (32 bits) times 1000 (10 bits) fits in 42 bits
    localparam int WIN_W     = 42;
    localparam int US_PER_MS = 1000;

    typedef struct packed {
        logic [1:0]  strategy;
        logic [7:0]  restart_limit;
        logic [31:0] period_ms;
        logic [4:0]  child_count;
        logic [31:0] restart_types;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/srp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the restart timestamp ring.
`default_nettype none

module srp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/srp_cfg.sv @@
// APB-style configuration register file for the restart policy.
// Depends on srp_pkg for the register indexes and the t_cfg struct.
`default_nettype none

module srp_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [srp_pkg::DATA_W-1:0]    pwdata,
    output logic      [srp_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    output srp_pkg::t_cfg                      o_cfg
);

    srp_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                srp_pkg::REG_STRATEGY:      r_cfg.strategy      <= pwdata[1:0];
                srp_pkg::REG_RESTART_LIMIT: r_cfg.restart_limit <= pwdata[7:0];
                srp_pkg::REG_PERIOD_MS:     r_cfg.period_ms     <= pwdata;
                srp_pkg::REG_CHILD_COUNT:   r_cfg.child_count   <= pwdata[4:0];
                srp_pkg::REG_RESTART_TYPES: r_cfg.restart_types <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            srp_pkg::REG_STRATEGY:      prdata = {30'b0, r_cfg.strategy};
            srp_pkg::REG_RESTART_LIMIT: prdata = {24'b0, r_cfg.restart_limit};
            srp_pkg::REG_PERIOD_MS:     prdata = r_cfg.period_ms;
            srp_pkg::REG_CHILD_COUNT:   prdata = {27'b0, r_cfg.child_count};
            srp_pkg::REG_RESTART_TYPES: prdata = r_cfg.restart_types;
            default:                    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/srp_win.sv @@
// Shared window comparator: one timestamp per enabled cycle, counts hits in the window.
// Depends on srp_pkg for the time and window widths.
`default_nettype none

module srp_win #(
    parameter int CNT_W = 5
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_clr,
    input  wire logic                          i_en,
    input  wire logic [srp_pkg::TIME_W-1:0]    i_now,
    input  wire logic [srp_pkg::TIME_W-1:0]    i_entry,
    input  wire logic [srp_pkg::WIN_W-1:0]     i_window,
    output logic      [CNT_W-1:0]              o_count
);

    logic [srp_pkg::TIME_W-1:0] age;
    logic                       hit;
    logic [CNT_W-1:0]           r_count;

    // Age of the entry, modulo 2^64, against the window
    assign age = i_now - i_entry;
    assign hit = age <= srp_pkg::TIME_W'(i_window);
    assign o_count = r_count;

    // Clear at the start of a pass, advance on each hit
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_count <= '0;
        end else if (i_en && hit) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ rtl/supervisor_restart_policy.sv @@
// Supervisor restart policy: one child-exit item in, one action item out.
// Item path: S_IDLE, S_DECIDE, then S_DONE when no restart is logged; a restart adds
// S_LOG, and with a nonzero limit S_COUNT, where one comparator walks the fill entries.
// Throughput: one item at a time, the next taken the cycle after the result registers;
// a finished result may wait in the output register. Reset (synchronous, active low)
// clears the control registers, ring head/fill and halt among them, not the payload.
`default_nettype none

module supervisor_restart_policy (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [srp_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [srp_pkg::DATA_W-1:0]    pwdata,
    output logic      [srp_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [3:0]                    i_child_index,
    input  wire logic                          i_exit_normal,
    input  wire logic [srp_pkg::TIME_W-1:0]    i_now_us,
    // output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [2:0]                    o_action,
    output logic      [3:0]                    o_first_child,
    output logic      [3:0]                    o_last_child
);

    localparam int AW = (srp_pkg::MAX_CHILDREN > 1) ? $clog2(srp_pkg::MAX_CHILDREN) : 1;
    localparam int FW = $clog2(srp_pkg::MAX_CHILDREN + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_LOG    = 5'b00100,
        S_COUNT  = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    srp_pkg::t_cfg cfg;

    t_state                     r_state, n_state;
    logic [3:0]                 r_idx;
    logic                       r_normal;
    logic [srp_pkg::TIME_W-1:0] r_now;
    logic [srp_pkg::WIN_W-1:0]  r_window;
    logic [AW-1:0]              r_head, n_head;
    logic [FW-1:0]              r_fill, n_fill;
    logic [AW-1:0]              r_rd_ptr, n_rd_ptr;
    logic [FW-1:0]              r_rd_left, n_rd_left;
    logic                       r_cmp_vld, n_cmp_vld;
    logic                       r_halted, n_halted;
    logic [2:0]                 r_act, n_act;
    logic                       r_out_valid, n_out_valid;
    logic [2:0]                 r_action;
    logic [3:0]                 r_first, r_last;

    logic [4:0]                 count;
    logic [1:0]                 kind;
    logic                       wants;
    logic                       ram_we;
    logic [srp_pkg::TIME_W-1:0] ram_rdata;
    logic                       win_clr;
    logic [FW-1:0]              hits;
    logic                       take_in;
    logic                       out_free;
    logic [3:0]                 range_first, range_last;

    // Configuration registers
    srp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Timestamp ring
    srp_ram #(
        .WIDTH (srp_pkg::TIME_W),
        .DEPTH (srp_pkg::MAX_CHILDREN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_head),
        .i_wdata (r_now),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // Window comparator, fed one ring entry per cycle
    srp_win #(
        .CNT_W (FW)
    ) u_win (
        .i_clk    (i_clk),
        .i_clr    (win_clr),
        .i_en     (r_cmp_vld),
        .i_now    (r_now),
        .i_entry  (ram_rdata),
        .i_window (r_window),
        .o_count  (hits)
    );

    // Effective child count, clamped to the ring size
    assign count = (32'(cfg.child_count) > srp_pkg::MAX_CHILDREN)
                 ? 5'(srp_pkg::MAX_CHILDREN) : cfg.child_count;
    assign kind  = cfg.restart_types[2*r_idx +: 2];
    assign wants = (kind == srp_pkg::KIND_PERMANENT) ||
                   ((kind == srp_pkg::KIND_TRANSIENT) && !r_normal);

    // Range to stop and restart
    always_comb begin
        range_last = 4'(count - 5'd1);
        unique case (cfg.strategy)
            srp_pkg::STRAT_ONE_FOR_ONE: begin
                range_first = r_idx;
                range_last  = r_idx;
            end
            srp_pkg::STRAT_ONE_FOR_ALL:  range_first = '0;
            default:                     range_first = r_idx;
        endcase
    end

    assign take_in  = i_in_valid && r_state == S_IDLE;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign ram_we  = (r_state == S_LOG);
    assign win_clr = (r_state == S_LOG);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_rd_ptr    = r_rd_ptr;
        n_rd_left   = r_rd_left;
        n_cmp_vld   = 1'b0;
        n_halted    = r_halted;
        n_act       = r_act;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (r_halted) begin
                    n_act   = srp_pkg::ACT_HALTED;
                    n_state = S_DONE;
                end else if ({1'b0, r_idx} >= count) begin
                    n_act   = srp_pkg::ACT_IGNORED;
                    n_state = S_DONE;
                end else if (cfg.strategy == srp_pkg::STRAT_UNKNOWN) begin
                    n_act    = srp_pkg::ACT_BAD_STRATEGY;
                    n_halted = 1'b1;
                    n_state  = S_DONE;
                end else if (!wants) begin
                    n_act   = srp_pkg::ACT_NO_RESTART;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOG;
                end
            end
            S_LOG: begin
                // Store the timestamp; with a nonzero limit, walk back from the newest entry
                n_head    = (r_head == AW'(srp_pkg::MAX_CHILDREN - 1)) ? '0
                                                                        : r_head + AW'(1);
                n_fill    = (r_fill == FW'(srp_pkg::MAX_CHILDREN)) ? r_fill
                                                                    : r_fill + FW'(1);
                n_rd_ptr  = r_head;
                n_rd_left = n_fill;
                if (cfg.restart_limit == 8'd0) begin
                    n_act   = srp_pkg::ACT_RESTART;
                    n_state = S_DONE;
                end else begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (r_rd_left != '0) begin
                    n_rd_ptr  = (r_rd_ptr == '0) ? AW'(srp_pkg::MAX_CHILDREN - 1)
                                                 : r_rd_ptr - AW'(1);
                    n_rd_left = r_rd_left - FW'(1);
                    n_cmp_vld = 1'b1;
                end else if (!r_cmp_vld) begin
                    if (8'(hits) >= cfg.restart_limit) begin
                        n_act    = srp_pkg::ACT_INTENSITY;
                        n_halted = 1'b1;
                    end else begin
                        n_act = srp_pkg::ACT_RESTART;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_rd_left   <= '0;
            r_cmp_vld   <= 1'b0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_rd_left   <= n_rd_left;
            r_cmp_vld   <= n_cmp_vld;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: item capture, window, read pointer, result
    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        r_act    <= n_act;
        if (take_in) begin
            r_idx    <= i_child_index;
            r_normal <= i_exit_normal;
            r_now    <= i_now_us;
        end
        if (r_state == S_DECIDE) begin
            r_window <= srp_pkg::WIN_W'(cfg.period_ms) *
                        srp_pkg::WIN_W'(srp_pkg::US_PER_MS);
        end
        if (r_state == S_DONE && out_free) begin
            r_action <= r_act;
            if (r_act == srp_pkg::ACT_RESTART) begin
                r_first <= range_first;
                r_last  <= range_last;
            end else begin
                r_first <= '0;
                r_last  <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_first_child = r_first;
    assign o_last_child  = r_last;

endmodule

`default_nettype wire
